[hw/rtl/wav_riff_header_parser_defines.svh]
// Assertion macros for the WAV header parser checker.
`ifndef WAV_RIFF_HEADER_PARSER_DEFINES_SVH
`define WAV_RIFF_HEADER_PARSER_DEFINES_SVH

// Clocked assertion, held off while reset is asserted.
`define WAVHP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define WAVHP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hw/rtl/wavhp_pkg.sv]
// Types, codes and helpers for the WAV RIFF header parser.
`default_nettype none

package wavhp_pkg;

  typedef enum logic [3:0] {
    PH_RIFF_ID   = 4'd0,
    PH_RIFF_SIZE = 4'd1,
    PH_WAVE      = 4'd2,
    PH_CHUNK_HDR = 4'd3,
    PH_FMT_BODY  = 4'd4,
    PH_SKIP_BODY = 4'd5,
    PH_PAD       = 4'd6,
    PH_AUDIO     = 4'd7,
    PH_END       = 4'd8
  } phase_t;

  typedef enum logic [2:0] {
    ST_PARSING   = 3'd0,
    ST_HDR_DONE  = 3'd1,
    ST_AUDIO     = 3'd2,
    ST_BAD_RIFF  = 3'd3,
    ST_BAD_WAVE  = 3'd4,
    ST_TRUNCATED = 3'd5,
    ST_TRAILING  = 3'd6
  } status_t;

  localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
  localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
  localparam logic [31:0] TAG_DATA = 32'h4441_5441;
  localparam logic [23:0] TAG_FMT3 = 24'h46_4D54;

  localparam int OUT_DATA_W = 200;

  // ASCII a-z folded to A-Z
  function automatic logic [7:0] upcase(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h61 && b <= 8'h7A) begin
      r = b - 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

[hw/rtl/wav_riff_header_parser.sv]
// WAV RIFF header parser: byte stream in, status plus format fields out.
// An accepted byte's state update and result word, held in the output register, are
// one registered pass. Throughput: one byte per cycle while in_tready is high.
// in_tready drops only while a result word is held and out_tready is low.
// Reset (rst_n low, synchronous) clears the parse state, format fields and output valid.
`default_nettype none

module wav_riff_header_parser (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // input stream
  input  wire logic                                in_tvalid,
  output logic                                     in_tready,
  input  wire logic [7:0]                          in_tdata,   // [7:0] in_byte
  input  wire logic [0:0]                          in_tuser,   // [0] first_byte
  input  wire logic                                in_tlast,   // last_byte
  // result stream
  output logic                                     out_tvalid,
  input  wire logic                                out_tready,
  // [7:0] audio_byte, [23:8] format_code, [39:24] channel_count,
  // [71:40] sample_rate, [103:72] byte_rate, [119:104] frame_align,
  // [135:120] sample_bits, [167:136] data_length, [199:168] data_start
  output logic [wavhp_pkg::OUT_DATA_W-1:0]         out_tdata,
  output logic [2:0]                               out_tuser,  // [2:0] status
  output logic                                     out_tlast   // audio_last
);

  // --------------------------------------------------------------------------
  // Parse state
  // --------------------------------------------------------------------------
  wavhp_pkg::phase_t phase_r, phase_nxt;
  logic [31:0] field_cnt_r,  field_cnt_nxt;   // byte index inside the current field/body
  logic [31:0] chunk_tag_r,  chunk_tag_nxt;   // upcased id bytes, first byte highest
  logic [31:0] chunk_len_r,  chunk_len_nxt;   // little-endian chunk size
  logic [31:0] file_pos_r,   file_pos_nxt;    // offset of the next byte in the file
  logic [15:0] fmt_code_r,   fmt_code_nxt;
  logic [15:0] channels_r,   channels_nxt;
  logic [31:0] rate_r,       rate_nxt;
  logic [31:0] byte_rate_r,  byte_rate_nxt;
  logic [15:0] align_r,      align_nxt;
  logic [15:0] bits_r,       bits_nxt;
  logic [31:0] data_len_r,   data_len_nxt;
  logic [31:0] data_rem_r,   data_rem_nxt;    // audio bytes still to come
  logic [31:0] data_start_r, data_start_nxt;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [wavhp_pkg::OUT_DATA_W-1:0]  out_data_r;
  logic [2:0]                        out_user_r;
  logic                              out_last_r;

  // Per-byte result
  wavhp_pkg::status_t status;
  logic [7:0]         audio_byte;
  logic               audio_last;
  logic               accept;

  // The output register takes a new word whenever it is empty or being drained.
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;

  // --------------------------------------------------------------------------
  // Next state and result for one byte
  // --------------------------------------------------------------------------
  always_comb begin
    wavhp_pkg::phase_t ph;
    logic [31:0] fc_base;
    logic [31:0] len_base;
    logic [31:0] pos;
    logic [7:0]  b;
    logic [7:0]  ub;

    b  = in_tdata;
    ub = wavhp_pkg::upcase(in_tdata);

    // first_byte restarts from the reset state before this byte is handled
    if (in_tuser[0]) begin
      ph             = wavhp_pkg::PH_RIFF_ID;
      field_cnt_nxt  = '0;
      chunk_tag_nxt  = '0;
      chunk_len_nxt  = '0;
      pos            = '0;
      fmt_code_nxt   = '0;
      channels_nxt   = '0;
      rate_nxt       = '0;
      byte_rate_nxt  = '0;
      align_nxt      = '0;
      bits_nxt       = '0;
      data_len_nxt   = '0;
      data_rem_nxt   = '0;
      data_start_nxt = '0;
    end else begin
      ph             = phase_r;
      field_cnt_nxt  = field_cnt_r;
      chunk_tag_nxt  = chunk_tag_r;
      chunk_len_nxt  = chunk_len_r;
      pos            = file_pos_r;
      fmt_code_nxt   = fmt_code_r;
      channels_nxt   = channels_r;
      rate_nxt       = rate_r;
      byte_rate_nxt  = byte_rate_r;
      align_nxt      = align_r;
      bits_nxt       = bits_r;
      data_len_nxt   = data_len_r;
      data_rem_nxt   = data_rem_r;
      data_start_nxt = data_start_r;
    end

    fc_base      = field_cnt_nxt;
    len_base     = chunk_len_nxt;
    file_pos_nxt = pos + 32'd1;
    phase_nxt    = ph;
    status       = wavhp_pkg::ST_PARSING;
    audio_byte   = '0;
    audio_last   = 1'b0;

    case (ph)
      wavhp_pkg::PH_RIFF_ID,
      wavhp_pkg::PH_WAVE: begin
        chunk_tag_nxt = {chunk_tag_nxt[23:0], ub};
        field_cnt_nxt = fc_base + 32'd1;
        if (field_cnt_nxt >= 32'd4) begin
          field_cnt_nxt = '0;
          if (ph == wavhp_pkg::PH_RIFF_ID) begin
            if (chunk_tag_nxt != wavhp_pkg::TAG_RIFF) begin
              status    = wavhp_pkg::ST_BAD_RIFF;
              phase_nxt = wavhp_pkg::PH_END;
            end else begin
              phase_nxt = wavhp_pkg::PH_RIFF_SIZE;
            end
          end else begin
            if (chunk_tag_nxt != wavhp_pkg::TAG_WAVE) begin
              status    = wavhp_pkg::ST_BAD_WAVE;
              phase_nxt = wavhp_pkg::PH_END;
            end else begin
              phase_nxt = wavhp_pkg::PH_CHUNK_HDR;
            end
          end
          chunk_tag_nxt = '0;
        end
      end

      wavhp_pkg::PH_RIFF_SIZE: begin
        field_cnt_nxt = fc_base + 32'd1;
        if (field_cnt_nxt >= 32'd4) begin
          field_cnt_nxt = '0;
          phase_nxt     = wavhp_pkg::PH_WAVE;
        end
      end

      wavhp_pkg::PH_CHUNK_HDR: begin
        if (fc_base < 32'd4) begin
          // id bytes; a fresh header clears id and size
          if (fc_base == 32'd0) begin
            chunk_tag_nxt = {24'd0, ub};
            chunk_len_nxt = '0;
          end else begin
            chunk_tag_nxt = {chunk_tag_nxt[23:0], ub};
          end
          field_cnt_nxt = fc_base + 32'd1;
        end else begin
          // size bytes, least significant first
          chunk_len_nxt[{fc_base[1:0], 3'b000} +: 8] = b;
          field_cnt_nxt = fc_base + 32'd1;
          if (field_cnt_nxt >= 32'd8) begin
            field_cnt_nxt = '0;
            if (chunk_tag_nxt[31:8] == wavhp_pkg::TAG_FMT3) begin
              fmt_code_nxt  = '0;
              channels_nxt  = '0;
              rate_nxt      = '0;
              byte_rate_nxt = '0;
              align_nxt     = '0;
              bits_nxt      = '0;
              phase_nxt     = (chunk_len_nxt == 32'd0) ? wavhp_pkg::PH_CHUNK_HDR
                                                       : wavhp_pkg::PH_FMT_BODY;
            end else if (chunk_tag_nxt == wavhp_pkg::TAG_DATA) begin
              status         = wavhp_pkg::ST_HDR_DONE;
              data_len_nxt   = chunk_len_nxt;
              data_rem_nxt   = chunk_len_nxt;
              data_start_nxt = file_pos_nxt;
              phase_nxt      = (chunk_len_nxt == 32'd0) ? wavhp_pkg::PH_END
                                                        : wavhp_pkg::PH_AUDIO;
            end else begin
              phase_nxt     = (chunk_len_nxt == 32'd0) ? wavhp_pkg::PH_CHUNK_HDR
                                                       : wavhp_pkg::PH_SKIP_BODY;
            end
          end
        end
      end

      wavhp_pkg::PH_FMT_BODY,
      wavhp_pkg::PH_SKIP_BODY: begin
        // fields were cleared at the fmt header, so each body byte lands in its lane
        if (ph == wavhp_pkg::PH_FMT_BODY && fc_base[31:4] == 28'd0) begin
          case (fc_base[3:0])
            4'd0:    fmt_code_nxt[7:0]    = b;
            4'd1:    fmt_code_nxt[15:8]   = b;
            4'd2:    channels_nxt[7:0]    = b;
            4'd3:    channels_nxt[15:8]   = b;
            4'd4:    rate_nxt[7:0]        = b;
            4'd5:    rate_nxt[15:8]       = b;
            4'd6:    rate_nxt[23:16]      = b;
            4'd7:    rate_nxt[31:24]      = b;
            4'd8:    byte_rate_nxt[7:0]   = b;
            4'd9:    byte_rate_nxt[15:8]  = b;
            4'd10:   byte_rate_nxt[23:16] = b;
            4'd11:   byte_rate_nxt[31:24] = b;
            4'd12:   align_nxt[7:0]       = b;
            4'd13:   align_nxt[15:8]      = b;
            4'd14:   bits_nxt[7:0]        = b;
            4'd15:   bits_nxt[15:8]       = b;
            default: fmt_code_nxt         = fmt_code_nxt;
          endcase
        end
        field_cnt_nxt = fc_base + 32'd1;
        if (field_cnt_nxt == len_base) begin
          field_cnt_nxt = '0;
          // odd-sized chunks carry one pad byte
          phase_nxt     = len_base[0] ? wavhp_pkg::PH_PAD : wavhp_pkg::PH_CHUNK_HDR;
        end
      end

      wavhp_pkg::PH_PAD: begin
        field_cnt_nxt = '0;
        phase_nxt     = wavhp_pkg::PH_CHUNK_HDR;
      end

      wavhp_pkg::PH_AUDIO: begin
        status       = wavhp_pkg::ST_AUDIO;
        audio_byte   = b;
        data_rem_nxt = data_rem_nxt - 32'd1;
        if (data_rem_nxt == 32'd0) begin
          audio_last = 1'b1;
          phase_nxt  = wavhp_pkg::PH_END;
        end
      end

      default: begin
        status    = wavhp_pkg::ST_TRAILING;
        phase_nxt = wavhp_pkg::PH_END;
      end
    endcase

    // stream end: header never finished means truncated
    if (in_tlast) begin
      if (status == wavhp_pkg::ST_PARSING) begin
        status = wavhp_pkg::ST_TRUNCATED;
      end
      phase_nxt = wavhp_pkg::PH_END;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= wavhp_pkg::PH_RIFF_ID;
      field_cnt_r  <= '0;
      chunk_tag_r  <= '0;
      chunk_len_r  <= '0;
      file_pos_r   <= '0;
      fmt_code_r   <= '0;
      channels_r   <= '0;
      rate_r       <= '0;
      byte_rate_r  <= '0;
      align_r      <= '0;
      bits_r       <= '0;
      data_len_r   <= '0;
      data_rem_r   <= '0;
      data_start_r <= '0;
    end else if (accept) begin
      phase_r      <= phase_nxt;
      field_cnt_r  <= field_cnt_nxt;
      chunk_tag_r  <= chunk_tag_nxt;
      chunk_len_r  <= chunk_len_nxt;
      file_pos_r   <= file_pos_nxt;
      fmt_code_r   <= fmt_code_nxt;
      channels_r   <= channels_nxt;
      rate_r       <= rate_nxt;
      byte_rate_r  <= byte_rate_nxt;
      align_r      <= align_nxt;
      bits_r       <= bits_nxt;
      data_len_r   <= data_len_nxt;
      data_rem_r   <= data_rem_nxt;
      data_start_r <= data_start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload: no reset needed, qualified by out_valid_r
  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= {data_start_nxt, data_len_nxt, bits_nxt, align_nxt,
                     byte_rate_nxt, rate_nxt, channels_nxt, fmt_code_nxt, audio_byte};
      out_user_r <= status;
      out_last_r <= audio_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire

[hw/rtl/wavhp_chk.sv]
// Port-level checker for the WAV RIFF header parser, bound to the top level.
`default_nettype none
`include "wav_riff_header_parser_defines.svh"

module wavhp_chk (
  input wire logic                               clk,
  input wire logic                               rst_n,
  input wire logic                               in_tready,
  input wire logic                               out_tvalid,
  input wire logic                               out_tready,
  input wire logic [wavhp_pkg::OUT_DATA_W-1:0]   out_tdata,
  input wire logic [2:0]                         out_tuser,
  input wire logic                               out_tlast
);

  // stalled word holds
  `WAVHP_ASSERT(a_out_hold,
                out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
                && $stable(out_tuser) && $stable(out_tlast),
                "stalled result word changed")

  // an empty output register never blocks input
  `WAVHP_ASSERT(a_in_ready, !out_tvalid |-> in_tready, "input stalled with empty output")

  // end-of-data flag only rides on audio words
  `WAVHP_ASSERT(a_last_audio,
                out_tvalid && out_tlast |-> out_tuser == wavhp_pkg::ST_AUDIO,
                "audio_last on non-audio word")

  // audio byte lane is zero outside audio
  `WAVHP_ASSERT(a_audio_zero,
                out_tvalid && out_tuser != wavhp_pkg::ST_AUDIO |-> out_tdata[7:0] == 8'd0,
                "audio byte set on non-audio word")

endmodule

bind wav_riff_header_parser wavhp_chk u_wavhp_chk (.*);

`default_nettype wire

[tb/tb.sv]
// Self-checking testbench for the WAV RIFF header parser: directed table plus random files.
module tb;
  import wavhp_pkg::*;

  // Run sizing: the random part stops once this many words have gone in after the
  // directed table. The sender pauses until every expected result is back after the first
  // file that ends DRAIN_EVERY or more words past the previous pause.
  localparam int RANDOM_WORDS = 1750;
  localparam int DRAIN_EVERY  = 400;
  localparam int N_DIRECTED   = 23;

  // One input word as the sender sees it.
  typedef struct packed {
    logic [7:0] b;
    logic       first;
    logic       last;
  } file_word_t;

  // One predicted result word; fields in the order the output bus carries them.
  typedef struct {
    status_t     status;
    logic [7:0]  audio;
    logic        alast;
    logic [15:0] fmt_code;
    logic [15:0] chans;
    logic [31:0] srate;
    logic [31:0] brate;
    logic [15:0] align;
    logic [15:0] bits;
    logic [31:0] dlen;
    logic [31:0] dstart;
  } parse_result_t;

  // Directed row. Where typed is set, the status column is the expected status
  // and replaces the predicted one.
  typedef struct {
    logic [7:0] b;
    logic       first;
    logic       last;
    logic       typed;
    status_t    want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [7:0]   in_tdata;
  logic [0:0]   in_tuser;
  logic         in_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  always #1 clk = ~clk;

  wav_riff_header_parser dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------------------
  // Parser model state (mirror of the block's registers)
  // ---------------------------------------------------------------------------
  phase_t      ph_q;
  logic [31:0] field_cnt;
  logic [31:0] tag_acc;
  logic [31:0] chunk_len;
  logic [31:0] byte_pos;
  logic [15:0] fmt_code;
  logic [15:0] chan_cnt;
  logic [31:0] smp_rate;
  logic [31:0] byt_rate;
  logic [15:0] blk_align;
  logic [15:0] smp_bits;
  logic [31:0] data_len;
  logic [31:0] data_left;
  logic [31:0] data_off;

  parse_result_t parse_results_due[$];  // one entry per byte taken, oldest first
  file_word_t    file_words[$];         // the file now being sent
  int            mismatches  = 0;
  int            words_sent  = 0;
  int            burst_left  = 0;

  function automatic void clear_format();
    fmt_code  = '0;
    chan_cnt  = '0;
    smp_rate  = '0;
    byt_rate  = '0;
    blk_align = '0;
    smp_bits  = '0;
  endfunction

  function automatic void clear_parse();
    ph_q      = PH_RIFF_ID;
    field_cnt = '0;
    tag_acc   = '0;
    chunk_len = '0;
    byte_pos  = '0;
    data_len  = '0;
    data_left = '0;
    data_off  = '0;
    clear_format();
  endfunction

  // Ids compare case-blind: a-z is taken as A-Z.
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    if (c >= 8'h61 && c <= 8'h7A) begin
      return c - 8'h20;
    end
    return c;
  endfunction

  // Advance the model by one file byte and return the result word it produces.
  function automatic parse_result_t parse_byte(input logic [7:0] b, input logic first,
                                               input logic last);
    parse_result_t r;
    logic [31:0]   pos;
    int            off;
    if (first) begin
      clear_parse();
    end
    pos      = byte_pos;
    byte_pos = pos + 1;
    r.status = ST_PARSING;
    r.audio  = '0;
    r.alast  = 1'b0;
    case (ph_q)
      PH_RIFF_ID, PH_WAVE: begin
        tag_acc   = {tag_acc[23:0], fold_case(b)};
        field_cnt = field_cnt + 1;
        if (field_cnt >= 4) begin
          field_cnt = '0;
          if (ph_q == PH_RIFF_ID) begin
            if (tag_acc != TAG_RIFF) begin
              r.status = ST_BAD_RIFF;
              ph_q     = PH_END;
            end else begin
              ph_q = PH_RIFF_SIZE;
            end
          end else begin
            if (tag_acc != TAG_WAVE) begin
              r.status = ST_BAD_WAVE;
              ph_q     = PH_END;
            end else begin
              ph_q = PH_CHUNK_HDR;
            end
          end
          tag_acc = '0;
        end
      end
      PH_RIFF_SIZE: begin
        field_cnt = field_cnt + 1;
        if (field_cnt >= 4) begin
          field_cnt = '0;
          ph_q      = PH_WAVE;
        end
      end
      PH_CHUNK_HDR: begin
        if (field_cnt < 4) begin
          if (field_cnt == 0) begin
            tag_acc   = '0;
            chunk_len = '0;
          end
          tag_acc   = {tag_acc[23:0], fold_case(b)};
          field_cnt = field_cnt + 1;
        end else begin
          off = (field_cnt - 4) & 3;
          chunk_len[8*off +: 8] |= b;
          field_cnt = field_cnt + 1;
          if (field_cnt >= 8) begin
            field_cnt = '0;
            if (tag_acc[31:8] == TAG_FMT3) begin
              clear_format();
              ph_q = (chunk_len == 0) ? PH_CHUNK_HDR : PH_FMT_BODY;
            end else if (tag_acc == TAG_DATA) begin
              r.status  = ST_HDR_DONE;
              data_len  = chunk_len;
              data_left = chunk_len;
              data_off  = pos + 1;
              ph_q      = (chunk_len == 0) ? PH_END : PH_AUDIO;
            end else begin
              ph_q = (chunk_len == 0) ? PH_CHUNK_HDR : PH_SKIP_BODY;
            end
          end
        end
      end
      PH_FMT_BODY, PH_SKIP_BODY: begin
        // only fmt offsets 0..15 land in the format fields
        if (ph_q == PH_FMT_BODY && field_cnt < 16) begin
          off = field_cnt;
          if (off < 2) fmt_code[8*off +: 8] |= b;
          else if (off < 4) chan_cnt[8*(off-2) +: 8] |= b;
          else if (off < 8) smp_rate[8*(off-4) +: 8] |= b;
          else if (off < 12) byt_rate[8*(off-8) +: 8] |= b;
          else if (off < 14) blk_align[8*(off-12) +: 8] |= b;
          else smp_bits[8*(off-14) +: 8] |= b;
        end
        field_cnt = field_cnt + 1;
        if (field_cnt == chunk_len) begin
          field_cnt = '0;
          ph_q      = chunk_len[0] ? PH_PAD : PH_CHUNK_HDR;  // odd body: one pad byte
        end
      end
      PH_PAD: begin
        field_cnt = '0;
        ph_q      = PH_CHUNK_HDR;
      end
      PH_AUDIO: begin
        r.status  = ST_AUDIO;
        r.audio   = b;
        data_left = data_left - 1;
        if (data_left == 0) begin
          r.alast = 1'b1;
          ph_q    = PH_END;
        end
      end
      default: begin
        r.status = ST_TRAILING;
        ph_q     = PH_END;
      end
    endcase
    // end of stream: truncated if nothing else was reported, then stop
    if (last) begin
      if (r.status == ST_PARSING) begin
        r.status = ST_TRUNCATED;
      end
      ph_q = PH_END;
    end
    r.fmt_code = fmt_code;
    r.chans    = chan_cnt;
    r.srate    = smp_rate;
    r.brate    = byt_rate;
    r.align    = blk_align;
    r.bits     = smp_bits;
    r.dlen     = data_len;
    r.dstart   = data_off;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Directed table: bad ids, truncation, trailing bytes, case folding, and a
  // start straight out of reset with no first flag.
  // ---------------------------------------------------------------------------
  dir_row_t directed_rows [N_DIRECTED] = '{
    // RIFX with no first flag: parser already waits for RIFF after reset
    '{"R",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"I",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"F",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"X",   1'b0, 1'b0, 1'b1, ST_BAD_RIFF},
    '{8'h00, 1'b0, 1'b0, 1'b1, ST_TRAILING},   // stopped parser
    '{8'hFF, 1'b1, 1'b1, 1'b1, ST_TRUNCATED},  // one-byte file
    // good mixed-case riff id, but the stream ends on its last byte
    '{"r",   1'b1, 1'b0, 1'b1, ST_PARSING},
    '{"I",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"f",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"F",   1'b0, 1'b1, 1'b1, ST_TRUNCATED},
    // full header with a bad wave type
    '{"R",   1'b1, 1'b0, 1'b1, ST_PARSING},
    '{"i",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"F",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"f",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},    // riff size, ignored
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
    '{8'h00, 1'b0, 1'b0, 1'b0, ST_PARSING},
    '{8'hFF, 1'b0, 1'b0, 1'b0, ST_PARSING},
    '{"w",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"a",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"v",   1'b0, 1'b0, 1'b1, ST_PARSING},
    '{"x",   1'b0, 1'b0, 1'b1, ST_BAD_WAVE},
    '{8'hFF, 1'b0, 1'b1, 1'b1, ST_TRAILING}    // last flag on a stopped parser
  };

  // ---------------------------------------------------------------------------
  // Sender: bursts of random length, random gaps between them
  // ---------------------------------------------------------------------------
  task automatic send_word(input file_word_t w, input logic typed, input status_t want);
    parse_result_t r;
    int            gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(9) < 3) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= w.b;
    in_tuser  <= w.first;
    in_tlast  <= w.last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    // word taken at this edge
    r = parse_byte(w.b, w.first, w.last);
    if (typed) begin
      r.status = want;
    end
    parse_results_due.push_back(r);
    words_sent++;
  endtask

  // Hold off new words until every expected result has come back.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (parse_results_due.size() != 0) @(posedge clk);
    burst_left = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Random file builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] mix_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(1) != 0) begin
      return c | 8'h20;
    end
    return c;
  endfunction

  function automatic void push_byte(input logic [7:0] b);
    file_word_t w;
    w.b     = b;
    w.first = 1'b0;
    w.last  = 1'b0;
    file_words.push_back(w);
  endfunction

  function automatic void push_tag(input logic [31:0] tag);
    for (int i = 3; i >= 0; i--) begin
      push_byte(mix_case(tag[8*i +: 8]));
    end
  endfunction

  function automatic void push_le32(input logic [31:0] v);
    for (int i = 0; i < 4; i++) begin
      push_byte(v[8*i +: 8]);
    end
  endfunction

  // RIFF/WAVE header, 0..3 fmt/foreign chunks, then a DATA chunk and its bytes, unless a
  // huge chunk ends the file. Audio count is sometimes short of or past the data length.
  function automatic void build_wave_file();
    logic [31:0] len;
    logic [31:0] tag;
    logic [7:0]  fourth;
    int          n_chunks;
    int          n_audio;
    int          pick;
    push_tag(TAG_RIFF);
    push_le32($urandom);
    push_tag(TAG_WAVE);
    n_chunks = $urandom_range(0, 3);
    for (int k = 0; k < n_chunks; k++) begin
      if ($urandom_range(2) != 0) begin
        fourth = 8'($urandom_range(255));
        push_tag({TAG_FMT3, fourth});
        len = ($urandom_range(9) < 6) ? 16 : $urandom_range(0, 20);
      end else begin
        tag = ($urandom_range(3) == 0) ? "LIST" : $urandom;
        push_tag(tag);
        len = ($urandom_range(39) == 0) ? 32'hFFFF_FFFF : $urandom_range(0, 9);
      end
      push_le32(len);
      if (len == 32'hFFFF_FFFF) begin
        // huge skipped chunk: a few body bytes and the file ends there
        repeat ($urandom_range(1, 6)) push_byte(8'($urandom));
        return;
      end
      for (int i = 0; i < len; i++) begin
        push_byte(8'($urandom));
      end
      if (len[0]) begin
        push_byte(8'($urandom));
      end
    end
    push_tag(TAG_DATA);
    pick = $urandom_range(19);
    if (pick == 0) len = 0;
    else if (pick == 1) len = 32'hFFFF_FFFF;
    else len = $urandom_range(1, 12);
    push_le32(len);
    n_audio = (len > 12) ? $urandom_range(1, 8) : len;
    pick = $urandom_range(9);
    if (pick == 0 && n_audio > 0) n_audio = $urandom_range(0, n_audio - 1);
    else if (pick == 1) n_audio += $urandom_range(1, 4);
    repeat (n_audio) push_byte(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver: ready pattern switches mode whenever the 6-bit tick counter wraps
  //   0: always ready, 1: ready about 3 in 4, 2: ready apart from random runs of stalled cycles
  // ---------------------------------------------------------------------------
  logic [1:0] rx_mode  = 2'd0;
  logic [5:0] rx_tick  = 6'd0;
  logic [4:0] rx_stall = 5'd0;

  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd63) begin
      rx_mode <= 2'($urandom_range(2));
    end
    case (rx_mode)
      2'd0: begin
        out_tready <= 1'b1;
      end
      2'd1: begin
        out_tready <= ($urandom_range(3) != 0);
      end
      default: begin
        if (rx_stall != 0) begin
          out_tready <= 1'b0;
          rx_stall   <= rx_stall - 5'd1;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(6) == 0) begin
            rx_stall <= 5'($urandom_range(1, 16));
          end
        end
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Result checker
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    parse_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (parse_results_due.size() == 0) begin
        $error("result word with no byte pending");
        mismatches++;
      end else begin
        e = parse_results_due.pop_front();
        check_field("status",        32'(e.status),   32'(out_tuser));
        check_field("audio_byte",    32'(e.audio),    32'(out_tdata[7:0]));
        check_field("audio_last",    32'(e.alast),    32'(out_tlast));
        check_field("format_code",   32'(e.fmt_code), 32'(out_tdata[23:8]));
        check_field("channel_count", 32'(e.chans),    32'(out_tdata[39:24]));
        check_field("sample_rate",   e.srate,         out_tdata[71:40]);
        check_field("byte_rate",     e.brate,         out_tdata[103:72]);
        check_field("frame_align",   32'(e.align),    32'(out_tdata[119:104]));
        check_field("sample_bits",   32'(e.bits),     32'(out_tdata[135:120]));
        check_field("data_length",   e.dlen,          out_tdata[167:136]);
        check_field("data_start",    e.dstart,        out_tdata[199:168]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    file_word_t w;
    int         kind;
    int         cut;
    int         idx;
    int         next_drain;
    int         guard;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    in_tlast  = 1'b0;
    clear_parse();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      w.b     = directed_rows[i].b;
      w.first = directed_rows[i].first;
      w.last  = directed_rows[i].last;
      send_word(w, directed_rows[i].typed, directed_rows[i].want);
    end
    drain_results();

    // Mostly well-formed files with random content; some broken, some noise.
    next_drain = words_sent + DRAIN_EVERY;
    while (words_sent < N_DIRECTED + RANDOM_WORDS) begin
      file_words.delete();
      kind = $urandom_range(99);
      if (kind < 90) begin
        build_wave_file();
        if (kind >= 75) begin
          if ($urandom_range(1) != 0) begin
            idx     = $urandom_range(file_words.size() - 1);
            w       = file_words[idx];
            w.b     = 8'($urandom);
            file_words[idx] = w;
          end else begin
            cut = $urandom_range(1, file_words.size());
            while (file_words.size() > cut) void'(file_words.pop_back());
          end
        end
        w       = file_words[0];
        w.first = ($urandom_range(9) != 0);
        file_words[0] = w;
        idx     = file_words.size() - 1;
        w       = file_words[idx];
        w.last  = ($urandom_range(9) < 6);
        file_words[idx] = w;
      end else begin
        repeat ($urandom_range(1, 12)) begin
          w.b     = 8'($urandom);
          w.first = ($urandom_range(4) == 0);
          w.last  = ($urandom_range(9) == 0);
          file_words.push_back(w);
        end
      end
      foreach (file_words[i]) begin
        send_word(file_words[i], 1'b0, ST_PARSING);
      end
      if (words_sent >= next_drain) begin
        drain_results();
        next_drain = words_sent + DRAIN_EVERY;
      end
    end

    // wind down: wait out the queue, then idle on to catch strays
    in_tvalid <= 1'b0;
    guard = 0;
    while (parse_results_due.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (parse_results_due.size() != 0) begin
      $error("%0d result words never arrived", parse_results_due.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // hang guard, far beyond the slowest legal run
  initial begin
    #1_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
